@@ rtl/upd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;

  // Depth of the result buffer; an item can produce at most this many results.
  localparam int unsigned OUT_DEPTH = 2;
  localparam int unsigned CNT_W     = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_PCT  = 2'd1,
    PHASE_HELD = 2'd2
  } upd_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } upd_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    upd_item_t        item0;
    upd_item_t        item1;
    upd_phase_e       phase_next;
    logic [7:0]       held_next;
  } upd_decode_t;

endpackage

`default_nettype wire

@@ rtl/upd_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

@@ rtl/uri_percent_decoder.sv @@
// Percent decoder for URI strings.
//
// The input channel carries one raw byte per transfer, with in_last set on
// the final byte of a string. The output channel carries decoded bytes with
// out_last set on the final decoded byte. A '+' becomes a space, a '%' and
// the two bytes after it collapse into one byte read as a base-16 number,
// and every other byte passes through. When a string ends one byte after a
// '%', two results come out: the '%' itself and then the final byte.
//
// An input transfer loads the input register; once all of the item's results
// fit, they are written from the input register into the result buffer, and
// the head of that buffer is offered. Throughput is one byte per cycle while
// the receiver keeps up; input is held only when the pending item's results
// do not all fit in the two-entry result buffer.
//
// When the receiver stalls, results wait in the buffer and input ready drops
// as soon as the pending item's results would not fit. Reset empties the
// input register and the result buffer and clears any pending escape.
`timescale 1ns / 1ps
`default_nettype none

module uri_percent_decoder import upd_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  upd_in_if.sink     in_ch,
  upd_out_if.source  out_ch
);

  // Input register.
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  // Escape state, advanced whenever the registered item moves on.
  upd_phase_e phase_q;
  logic [7:0] held_q;

  // Result buffer; entry 0 is the head.
  upd_item_t        buf_q [OUT_DEPTH];
  upd_item_t        buf_d [OUT_DEPTH];
  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;

  upd_decode_t      dec;
  logic             pop;
  logic             s1_take;
  logic [CNT_W-1:0] kept;
  logic [CNT_W-1:0] free;

  upd_decode u_decode (
    .phase_i (phase_q),
    .held_i  (held_q),
    .byte_i  (s1_byte_q),
    .last_i  (s1_last_q),
    .res_o   (dec)
  );

  assign out_ch.valid    = (count_q != '0);
  assign out_ch.out_byte = buf_q[0].data;
  assign out_ch.out_last = buf_q[0].last;

  assign pop  = out_ch.valid && out_ch.ready;
  assign kept = count_q - CNT_W'(pop);
  assign free = CNT_W'(OUT_DEPTH) - kept;

  // The registered item leaves only when all of its results fit.
  assign s1_take     = s1_valid_q && (dec.count <= free);
  assign in_ch.ready = !s1_valid_q || s1_take;

  always_comb begin
    for (int i = 0; i < OUT_DEPTH; i++) begin
      buf_d[i] = buf_q[i];
    end
    if (pop) begin
      for (int i = 0; i < OUT_DEPTH - 1; i++) begin
        buf_d[i] = buf_q[i + 1];
      end
    end
    count_d = kept;
    if (s1_take) begin
      for (int i = 0; i < OUT_DEPTH; i++) begin
        if (CNT_W'(i) == kept && dec.count != '0) begin
          buf_d[i] = dec.item0;
        end else if (CNT_W'(i) == kept + CNT_W'(1) && dec.count == CNT_W'(2)) begin
          buf_d[i] = dec.item1;
        end
      end
      count_d = kept + dec.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      count_q    <= '0;
      phase_q    <= PHASE_IDLE;
      held_q     <= 8'd0;
    end else begin
      count_q <= count_d;
      if (in_ch.ready) begin
        s1_valid_q <= in_ch.valid;
      end
      if (s1_take) begin
        phase_q <= dec.phase_next;
        held_q  <= dec.held_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_q <= in_ch.in_byte;
      s1_last_q <= in_ch.in_last;
    end
    for (int i = 0; i < OUT_DEPTH; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/upd_decode.sv @@
`timescale 1ns / 1ps
`default_nettype none

module upd_decode import upd_pkg::*; (
  input  upd_phase_e  phase_i,
  input  logic [7:0]  held_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output upd_decode_t res_o
);

  // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  function automatic logic [7:0] plain_map(input logic [7:0] c);
    return (c == CHAR_PLUS) ? CHAR_SPACE : c;
  endfunction

  // Two characters read as strtol base 16 would, wrapped to a byte.
  function automatic logic [7:0] read_pair(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] da;
    logic [4:0] db;
    logic [7:0] v;
    logic [7:0] r;
    da = hex_digit(a);
    db = hex_digit(b);
    v  = db[4] ? {4'd0, db[3:0]} : 8'd0;
    if (da[4]) begin
      r = db[4] ? {da[3:0], db[3:0]} : {4'd0, da[3:0]};
    end else if (a == CHAR_SPACE || (a >= 8'd9 && a <= 8'd13) || a == CHAR_PLUS) begin
      r = v;
    end else if (a == CHAR_MINUS) begin
      r = 8'(8'd0 - v);
    end else begin
      r = 8'd0;
    end
    return r;
  endfunction

  always_comb begin
    res_o            = '0;
    res_o.phase_next = PHASE_IDLE;
    res_o.held_next  = 8'd0;
    unique case (phase_i)
      PHASE_PCT: begin
        if (last_i) begin
          // The string ended one byte into an escape: flush it literally.
          res_o.count = CNT_W'(2);
          res_o.item0 = '{data: CHAR_PERCENT, last: 1'b0};
          res_o.item1 = '{data: plain_map(byte_i), last: 1'b1};
        end else begin
          res_o.phase_next = PHASE_HELD;
          res_o.held_next  = byte_i;
        end
      end
      PHASE_HELD: begin
        res_o.count = CNT_W'(1);
        res_o.item0 = '{data: read_pair(held_i, byte_i), last: last_i};
      end
      default: begin
        if (byte_i == CHAR_PERCENT && !last_i) begin
          res_o.phase_next = PHASE_PCT;
        end else begin
          res_o.count = CNT_W'(1);
          res_o.item0 = '{data: plain_map(byte_i), last: last_i};
        end
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/upd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module upd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       in_last_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i
);

  // Strings whose final byte went in but whose final result has not come out.
  logic [2:0] open_q;
  logic       in_end;
  logic       out_end;

  assign in_end  = in_valid_i && in_ready_i && in_last_i;
  assign out_end = out_valid_i && out_ready_i && out_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 3'd0;
    end else begin
      open_q <= 3'(open_q + 3'(in_end) - 3'(out_end));
    end
  end

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result offered during reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled result changed");

  a_end_follows_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_end |-> open_q != 3'd0)
    else $error("string end delivered without a matching input end");

  a_open_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 3'd3)
    else $error("more strings in flight than the pipeline can hold");

endmodule

bind uri_percent_decoder upd_checker u_upd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch.valid),
  .in_ready_i  (in_ch.ready),
  .in_last_i   (in_ch.in_last),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_byte_i  (out_ch.out_byte),
  .out_last_i  (out_ch.out_last)
);

`default_nettype wire
